### src/dda_pkg.sv
package dda_pkg;

  // Width of the pixel coordinate fields on the ports
  localparam int unsigned PIX_W = 6;

  // Program counter of the sequencer
  localparam int unsigned PC_W = 3;

  typedef struct packed {
    logic [PIX_W-1:0] x_start;
    logic [PIX_W-1:0] y_start;
    logic [PIX_W-1:0] x_end;
    logic [PIX_W-1:0] y_end;
  } line_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             last_pixel;
  } pixel_t;

  // Datapath operation selected by a control word
  typedef enum logic [2:0] {
    OP_FETCH,
    OP_SETUP,
    OP_DIV_INT,
    OP_DIV_FRAC,
    OP_FINISH,
    OP_EMIT
  } op_e;

  // Branch condition of a control word
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_XFER,
    COND_STEPS_ZERO,
    COND_DIV_DONE,
    COND_LINE_DONE
  } cond_e;

  // One microcode word: taken branch goes to target, otherwise hold or fall through
  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic            hold;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_FETCH    = 3'd0;
  localparam logic [PC_W-1:0] PC_SETUP    = 3'd1;
  localparam logic [PC_W-1:0] PC_DIV_INT  = 3'd2;
  localparam logic [PC_W-1:0] PC_DIV_FRAC = 3'd3;
  localparam logic [PC_W-1:0] PC_FINISH   = 3'd4;
  localparam logic [PC_W-1:0] PC_EMIT     = 3'd5;

  // Control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_FETCH:    w = '{op: OP_FETCH,    cond: COND_IN_XFER,    hold: 1'b1, target: PC_SETUP};
      PC_SETUP:    w = '{op: OP_SETUP,    cond: COND_STEPS_ZERO, hold: 1'b0, target: PC_FINISH};
      PC_DIV_INT:  w = '{op: OP_DIV_INT,  cond: COND_ALWAYS,     hold: 1'b0, target: PC_DIV_FRAC};
      PC_DIV_FRAC: w = '{op: OP_DIV_FRAC, cond: COND_DIV_DONE,   hold: 1'b1, target: PC_FINISH};
      PC_FINISH:   w = '{op: OP_FINISH,   cond: COND_ALWAYS,     hold: 1'b0, target: PC_EMIT};
      PC_EMIT:     w = '{op: OP_EMIT,     cond: COND_LINE_DONE,  hold: 1'b1, target: PC_FETCH};
      default:     w = '{op: OP_FETCH,    cond: COND_ALWAYS,     hold: 1'b0, target: PC_FETCH};
    endcase
    return w;
  endfunction

endpackage

### src/dda_line_rasterizer.sv
// Steps per line: fetch on the input transfer, setup, the integer divide step, the fraction
// divide steps, finish, then emit; equal endpoints skip the divider and go on to finish.
// A new line is taken only after the last pixel of the previous one has been emitted;
// pixels leave at one per cycle while the output does not stall, and output stalls hold them.
// The divider is bit-serial, one quotient bit per cycle for both axes.
// Reset: asynchronous, active low; sequencer to the fetch step, output register emptied.
module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS    = 6,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dda_pkg::line_req_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dda_pkg::pixel_t    out_data_o
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned W   = C + 1 + F;
  localparam int unsigned CNT = $clog2(F);

  // Sequencer
  logic [dda_pkg::PC_W-1:0] pc_q, pc_d;
  dda_pkg::ucode_t          uw;
  logic                     cond_ok;

  // Captured endpoints
  logic [C-1:0] xs_q, ys_q, xe_q, ye_q;

  // Setup arithmetic
  logic [C:0]   dx, dy;
  logic [C:0]   dx_neg, dy_neg;
  logic [C-1:0] adx, ady, steps_c;

  // Divider lanes
  logic [C-1:0]   div_q;
  logic [C:0]     rx_q, ry_q;
  logic [F:0]     qx_q, qy_q;
  logic           negx_q, negy_q;
  logic [CNT-1:0] cnt_q;
  logic [C:0]     tx, ty;
  logic           bx, by;

  // Walk
  logic [W-1:0] accx_q, accy_q, incx_q, incy_q;
  logic [C-1:0] rem_q;
  logic         emit_fire;

  // Output register
  logic            out_valid_q, out_valid_d;
  dda_pkg::pixel_t out_q;

  assign uw = dda_pkg::ucode_rom(pc_q);

  // Axis distances and step count
  assign dx      = {1'b0, xe_q} - {1'b0, xs_q};
  assign dy      = {1'b0, ye_q} - {1'b0, ys_q};
  assign dx_neg  = -dx;
  assign dy_neg  = -dy;
  assign adx     = dx[C] ? dx_neg[C-1:0] : dx[C-1:0];
  assign ady     = dy[C] ? dy_neg[C-1:0] : dy[C-1:0];
  assign steps_c = (adx > ady) ? adx : ady;

  // One restoring division step per lane: shift in a zero (not in the integer step), compare, subtract
  always_comb begin
    if (uw.op == dda_pkg::OP_DIV_INT) begin
      tx = rx_q;
      ty = ry_q;
    end else begin
      tx = {rx_q[C-1:0], 1'b0};
      ty = {ry_q[C-1:0], 1'b0};
    end
    bx = (tx >= {1'b0, div_q});
    by = (ty >= {1'b0, div_q});
  end

  assign emit_fire = (uw.op == dda_pkg::OP_EMIT) && (!out_valid_q || !out_stall_i);

  // Branch condition
  always_comb begin
    case (uw.cond)
      dda_pkg::COND_ALWAYS:     cond_ok = 1'b1;
      dda_pkg::COND_IN_XFER:    cond_ok = in_valid_i;
      dda_pkg::COND_STEPS_ZERO: cond_ok = (steps_c == '0);
      dda_pkg::COND_DIV_DONE:   cond_ok = (cnt_q == '0);
      dda_pkg::COND_LINE_DONE:  cond_ok = emit_fire && (rem_q == '0);
      default:                  cond_ok = 1'b1;
    endcase
  end

  // Next program address
  always_comb begin
    if (cond_ok) begin
      pc_d = uw.target;
    end else if (uw.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= dda_pkg::PC_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Datapath driven by the current control word
  always_ff @(posedge clk_i) begin
    case (uw.op)
      dda_pkg::OP_FETCH: begin
        if (in_valid_i) begin
          xs_q <= in_data_i.x_start[C-1:0];
          ys_q <= in_data_i.y_start[C-1:0];
          xe_q <= in_data_i.x_end[C-1:0];
          ye_q <= in_data_i.y_end[C-1:0];
        end
      end
      dda_pkg::OP_SETUP: begin
        div_q  <= steps_c;
        rem_q  <= steps_c;
        rx_q   <= {1'b0, adx};
        ry_q   <= {1'b0, ady};
        qx_q   <= '0;
        qy_q   <= '0;
        negx_q <= dx[C];
        negy_q <= dy[C];
        cnt_q  <= CNT'(F - 1);
        accx_q <= {1'b0, xs_q, {F{1'b0}}};
        accy_q <= {1'b0, ys_q, {F{1'b0}}};
      end
      dda_pkg::OP_DIV_INT, dda_pkg::OP_DIV_FRAC: begin
        rx_q <= bx ? (tx - {1'b0, div_q}) : tx;
        ry_q <= by ? (ty - {1'b0, div_q}) : ty;
        qx_q <= {qx_q[F-1:0], bx};
        qy_q <= {qy_q[F-1:0], by};
        if (uw.op == dda_pkg::OP_DIV_FRAC) begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      dda_pkg::OP_FINISH: begin
        // Apply the axis direction to the unsigned quotient
        incx_q <= negx_q ? -W'(qx_q) : W'(qx_q);
        incy_q <= negy_q ? -W'(qy_q) : W'(qy_q);
      end
      dda_pkg::OP_EMIT: begin
        if (emit_fire) begin
          accx_q <= accx_q + incx_q;
          accy_q <= accy_q + incy_q;
          rem_q  <= rem_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: integer part of the accumulators, clamped at zero
  always_comb begin
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q.pixel_x    <= accx_q[W-1] ? '0 : dda_pkg::PIX_W'(accx_q[F +: C]);
      out_q.pixel_y    <= accy_q[W-1] ? '0 : dda_pkg::PIX_W'(accy_q[F +: C]);
      out_q.last_pixel <= (rem_q == '0);
    end
  end

  assign in_stall_o  = (uw.op != dda_pkg::OP_FETCH);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
